// ----- sv/cbsm_pkg.sv -----
`default_nettype none

package cbsm_pkg;

  localparam int OFS_W  = 20;
  localparam int BANK_W = 9;

  typedef logic [OFS_W-1:0]  ofs_t;
  typedef logic [BANK_W-1:0] bank_t;
  typedef logic [5:0]        mode_t;

  // mapping state, also what the result word shows
  typedef struct packed {
    bank_t bank;
    logic  low_en;
    logic  high_en;
    ofs_t  ofs_lo;
    ofs_t  ofs_a;
    ofs_t  ofs_b;
  } st_t;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_BASIC = 1'b1;

  localparam mode_t MD_STD8      = 6'd1;
  localparam mode_t MD_STD16     = 6'd2;
  localparam mode_t MD_OSS       = 6'd3;
  localparam mode_t MD_DB32      = 6'd4;
  localparam mode_t MD_WILL64    = 6'd5;
  localparam mode_t MD_WILL32    = 6'd6;
  localparam mode_t MD_EXP       = 6'd7;
  localparam mode_t MD_DIAMOND   = 6'd8;
  localparam mode_t MD_SDX64     = 6'd9;
  localparam mode_t MD_SDX128    = 6'd10;
  localparam mode_t MD_XEGS      = 6'd11;
  localparam mode_t MD_SWXEGS    = 6'd17;
  localparam mode_t MD_OSS2      = 6'd23;
  localparam mode_t MD_ATRAX     = 6'd24;
  localparam mode_t MD_BBSB      = 6'd25;
  localparam mode_t MD_RIGHT     = 6'd26;
  localparam mode_t MD_MEGA      = 6'd27;
  localparam mode_t MD_ATMAX128  = 6'd34;
  localparam mode_t MD_ATMAX1024 = 6'd35;
  localparam mode_t MD_PHOENIX   = 6'd36;
  localparam mode_t MD_BLIZZARD  = 6'd37;

  localparam logic [7:0] CLK_ADR0 = 8'hB8;
  localparam logic [7:0] CLK_ADR1 = 8'hB9;

  localparam int SH_4K  = 12;
  localparam int SH_8K  = 13;
  localparam int SH_16K = 14;

  localparam ofs_t OFS_4K      = 20'h01000;
  localparam ofs_t OFS_8K      = 20'h02000;
  localparam ofs_t OFS_OSS_FIX = 20'h03000;
  localparam ofs_t OFS_DB_FIX  = 20'h06000;
  localparam ofs_t OFS_AMX_TOP = 20'hFE000;
  localparam bank_t BANK_AMX_TOP = 9'h07F;

endpackage

`default_nettype wire

// ----- sv/cbsm_decode.sv -----
`default_nettype none

module cbsm_decode (
  input  wire cbsm_pkg::st_t   cur,
  input  wire cbsm_pkg::mode_t mode,
  input  wire logic            basic,
  input  wire logic [1:0]      act,
  input  wire logic [7:0]      adr,
  input  wire logic [7:0]      dat,
  output cbsm_pkg::st_t        nxt,
  output logic                 clk_acc,
  output logic                 basic_sel
);

  logic none_mode;
  logic clk_adr;
  cbsm_pkg::st_t cleared;

  function automatic cbsm_pkg::st_t f_high8(cbsm_pkg::st_t s, cbsm_pkg::ofs_t base);
    cbsm_pkg::st_t r;
    r = s;
    r.high_en = 1'b1;
    r.ofs_a   = base;
    r.ofs_b   = base + cbsm_pkg::OFS_4K;
    return r;
  endfunction

  function automatic cbsm_pkg::st_t f_low8(cbsm_pkg::st_t s, cbsm_pkg::ofs_t base);
    cbsm_pkg::st_t r;
    r = s;
    r.low_en = 1'b1;
    r.ofs_lo = base;
    return r;
  endfunction

  function automatic cbsm_pkg::ofs_t f_8k(logic [7:0] b);
    return cbsm_pkg::ofs_t'(b) << cbsm_pkg::SH_8K;
  endfunction

  // (4 << k) - 1
  function automatic logic [7:0] f_xmask(logic [2:0] k);
    logic [7:0] m;
    case (k)
      3'd0:    m = 8'h03;
      3'd1:    m = 8'h07;
      3'd2:    m = 8'h0F;
      3'd3:    m = 8'h1F;
      3'd4:    m = 8'h3F;
      default: m = 8'h7F;
    endcase
    return m;
  endfunction

  // (1 << j) - 1
  function automatic logic [7:0] f_mmask(logic [2:0] j);
    logic [7:0] m;
    case (j)
      3'd0:    m = 8'h00;
      3'd1:    m = 8'h01;
      3'd2:    m = 8'h03;
      3'd3:    m = 8'h07;
      3'd4:    m = 8'h0F;
      3'd5:    m = 8'h1F;
      default: m = 8'h3F;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] f_xk(cbsm_pkg::mode_t m);
    cbsm_pkg::mode_t dx;
    cbsm_pkg::mode_t dsw;
    dx  = m - cbsm_pkg::MD_XEGS;
    dsw = m - cbsm_pkg::MD_SWXEGS;
    return (m < cbsm_pkg::MD_SWXEGS) ? dx[2:0] : dsw[2:0];
  endfunction

  // 8K at 8000 switched, fixed bank at A000; bit 7 blanks both
  function automatic cbsm_pkg::st_t f_xegs(cbsm_pkg::st_t s, logic [7:0] b,
                                           cbsm_pkg::ofs_t fixed);
    cbsm_pkg::st_t r;
    r = s;
    if (b[7]) begin
      r.low_en  = 1'b0;
      r.high_en = 1'b0;
    end else begin
      r = f_low8(r, f_8k({1'b0, b[6:0]}));
      r = f_high8(r, fixed);
    end
    r.bank = cbsm_pkg::bank_t'(b);
    return r;
  endfunction

  function automatic cbsm_pkg::st_t f_mega(cbsm_pkg::st_t s, logic [7:0] b);
    cbsm_pkg::st_t r;
    cbsm_pkg::ofs_t base;
    r = s;
    base = cbsm_pkg::ofs_t'(b[6:0]) << cbsm_pkg::SH_16K;
    if (b[7]) begin
      r.low_en  = 1'b0;
      r.high_en = 1'b0;
    end else begin
      r = f_low8(r, base);
      r = f_high8(r, base + cbsm_pkg::OFS_8K);
    end
    r.bank = cbsm_pkg::bank_t'(b);
    return r;
  endfunction

  // switched 4K at A000, fixed 4K at B000
  function automatic cbsm_pkg::st_t f_oss(cbsm_pkg::st_t s, logic [1:0] b,
                                          cbsm_pkg::ofs_t fixed);
    cbsm_pkg::st_t r;
    r = s;
    r.high_en = 1'b1;
    r.ofs_a   = cbsm_pkg::ofs_t'(b) << cbsm_pkg::SH_4K;
    r.ofs_b   = fixed;
    r.bank    = cbsm_pkg::bank_t'(b);
    return r;
  endfunction

  function automatic cbsm_pkg::st_t f_hi_off(cbsm_pkg::st_t s, logic [7:0] a,
                                             logic [3:0] b8);
    cbsm_pkg::st_t r;
    r = s;
    if (a[3]) r.high_en = 1'b0;
    else      r = f_high8(r, f_8k({4'b0, b8}));
    r.bank = cbsm_pkg::bank_t'(a);
    return r;
  endfunction

  function automatic cbsm_pkg::st_t f_access(cbsm_pkg::st_t s, cbsm_pkg::mode_t m,
                                             logic [7:0] a);
    cbsm_pkg::st_t r;
    r = s;
    unique case (m)
      cbsm_pkg::MD_OSS: begin
        if (a[3]) begin
          r.high_en = 1'b0;
        end else begin
          case (a[2:0])
            3'd0, 3'd1: r = f_oss(r, 2'd0, cbsm_pkg::OFS_OSS_FIX);
            3'd3, 3'd7: r = f_oss(r, 2'd1, cbsm_pkg::OFS_OSS_FIX);
            3'd4, 3'd5: r = f_oss(r, 2'd2, cbsm_pkg::OFS_OSS_FIX);
            default: ;
          endcase
        end
      end
      cbsm_pkg::MD_OSS2: begin
        case ({a[3], a[0]})
          2'b00:   r = f_oss(r, 2'd1, '0);
          2'b01:   r = f_oss(r, 2'd3, '0);
          2'b11:   r = f_oss(r, 2'd2, '0);
          default: r.high_en = 1'b0;
        endcase
      end
      cbsm_pkg::MD_DB32:   r = f_xegs(r, {6'b0, a[1:0]}, cbsm_pkg::OFS_DB_FIX);
      cbsm_pkg::MD_WILL64: r = f_hi_off(r, a, {1'b0, a[2:0]});
      cbsm_pkg::MD_WILL32: r = f_hi_off(r, a, {2'b0, a[1:0]});
      cbsm_pkg::MD_EXP: begin
        if (a[7:4] == 4'h7) r = f_hi_off(r, a, {1'b0, ~a[2:0]});
      end
      cbsm_pkg::MD_DIAMOND: begin
        if (a[7:4] == 4'hD) r = f_hi_off(r, a, {1'b0, ~a[2:0]});
      end
      cbsm_pkg::MD_SDX64: begin
        if (a[7:4] == 4'hE) r = f_hi_off(r, a, {1'b0, ~a[2:0]});
      end
      cbsm_pkg::MD_SDX128: begin
        if (a[7:5] == 3'b111) r = f_hi_off(r, a, ~{a[4], a[2:0]});
      end
      cbsm_pkg::MD_PHOENIX: r.high_en = 1'b0;
      cbsm_pkg::MD_BLIZZARD: begin
        r.low_en  = 1'b0;
        r.high_en = 1'b0;
      end
      cbsm_pkg::MD_ATMAX128: begin
        if (a[7:4] == 4'h0) begin
          r = f_high8(r, f_8k(a));
          r.bank = cbsm_pkg::bank_t'(a);
        end else if (a[7:4] == 4'h1) begin
          r.high_en = 1'b0;
          r.bank = cbsm_pkg::bank_t'(a);
        end
      end
      cbsm_pkg::MD_ATMAX1024: begin
        if (a[7]) r.high_en = 1'b0;
        else      r = f_high8(r, f_8k(a));
        r.bank = cbsm_pkg::bank_t'(a);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cbsm_pkg::st_t f_write(cbsm_pkg::st_t s, cbsm_pkg::mode_t m,
                                            logic [7:0] a, logic [7:0] d);
    cbsm_pkg::st_t r;
    logic [7:0] xm;
    logic [7:0] mm;
    cbsm_pkg::mode_t dm;
    r  = s;
    xm = f_xmask(f_xk(m));
    dm = m - cbsm_pkg::MD_MEGA;
    mm = f_mmask(dm[2:0]);
    if (m >= cbsm_pkg::MD_XEGS && m < cbsm_pkg::MD_SWXEGS) begin
      r = f_xegs(r, d & xm, f_8k(xm));
    end else if (m >= cbsm_pkg::MD_SWXEGS && m < cbsm_pkg::MD_OSS2) begin
      r = f_xegs(r, d & (xm | 8'h80), f_8k(xm));
    end else if (m >= cbsm_pkg::MD_MEGA && m < cbsm_pkg::MD_ATMAX128) begin
      r = f_mega(r, d & (mm | 8'h80));
    end else if (m == cbsm_pkg::MD_ATRAX) begin
      if (d[7]) begin
        r.high_en = 1'b0;
      end else begin
        r = f_high8(r, f_8k({4'b0, d[3:0]}));
        r.bank = cbsm_pkg::bank_t'(d[3:0]);
      end
    end else begin
      r = f_access(r, m, a);
    end
    return r;
  endfunction

  // power-on map of the mode, from a cleared state
  function automatic cbsm_pkg::st_t f_start(cbsm_pkg::st_t s, cbsm_pkg::mode_t m,
                                            logic none_m, logic bas);
    cbsm_pkg::st_t r;
    logic [7:0] xm;
    r  = s;
    xm = f_xmask(f_xk(m));
    if (m == cbsm_pkg::MD_STD8 || m == cbsm_pkg::MD_PHOENIX) begin
      r = f_high8(r, '0);
    end else if (m == cbsm_pkg::MD_STD16 || m == cbsm_pkg::MD_BLIZZARD) begin
      r = f_low8(r, '0);
      r = f_high8(r, cbsm_pkg::OFS_8K);
    end else if (m == cbsm_pkg::MD_OSS) begin
      r = f_oss(r, 2'd0, cbsm_pkg::OFS_OSS_FIX);
    end else if (m == cbsm_pkg::MD_OSS2) begin
      r = f_oss(r, 2'd1, '0);
      r.bank = '0;
    end else if (m == cbsm_pkg::MD_DB32) begin
      r = f_low8(r, '0);
      r = f_high8(r, cbsm_pkg::OFS_DB_FIX);
    end else if ((m >= cbsm_pkg::MD_WILL64 && m <= cbsm_pkg::MD_SDX128) ||
                 m == cbsm_pkg::MD_ATRAX || m == cbsm_pkg::MD_ATMAX128) begin
      r = f_high8(r, '0);
    end else if (m >= cbsm_pkg::MD_XEGS && m < cbsm_pkg::MD_OSS2) begin
      r = f_low8(r, '0);
      r = f_high8(r, f_8k(xm));
    end else if (m >= cbsm_pkg::MD_MEGA && m < cbsm_pkg::MD_ATMAX128) begin
      r = f_low8(r, '0);
      r = f_high8(r, cbsm_pkg::OFS_8K);
    end else if (m == cbsm_pkg::MD_ATMAX1024) begin
      r = f_high8(r, cbsm_pkg::OFS_AMX_TOP);
      r.bank = cbsm_pkg::BANK_AMX_TOP;
    end else if (none_m) begin
      r.high_en = bas;
    end
    return r;
  endfunction

  assign none_mode = (mode == '0) || (mode > cbsm_pkg::MD_BLIZZARD);
  assign clk_adr   = (adr == cbsm_pkg::CLK_ADR0) || (adr == cbsm_pkg::CLK_ADR1);
  assign cleared   = '0;

  always_comb begin
    nxt     = cur;
    clk_acc = 1'b0;
    unique case (act)
      cbsm_pkg::ACT_READ: begin
        if (!none_mode) begin
          if (clk_adr) clk_acc = 1'b1;
          else         nxt = f_access(cur, mode, adr);
        end
      end
      cbsm_pkg::ACT_WRITE: begin
        if (clk_adr) clk_acc = 1'b1;
        else         nxt = f_write(cur, mode, adr, dat);
      end
      cbsm_pkg::ACT_START: nxt = f_start(cleared, mode, none_mode, basic);
      default: ;
    endcase
  end

  assign basic_sel = none_mode && basic && nxt.high_en;

endmodule

`default_nettype wire

// ----- sv/cartridge_bank_switch_mapper.sv -----
// path: an accepted input word is held in the input register; the decode between the
//   registers then updates the mapping state and result register together
// throughput: one word per cycle unless out_stall holds back a valid result
// reset (rst_n low, synchronous): no mapping, both windows off, bank and offsets zero,
//   mode_r and basic_r zero, both channels empty
`default_nettype none

module cartridge_bank_switch_mapper #(
  parameter int ROM_ADDR_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_address_low,
  input  wire logic [7:0]  in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_window_low_on,
  output logic             out_window_high_on,
  output logic [19:0]      out_offset_low_window,
  output logic [19:0]      out_offset_a_half,
  output logic [19:0]      out_offset_b_half,
  output logic             out_basic_selected,
  output logic             out_clock_access,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data
);

  localparam int OW = cbsm_pkg::OFS_W;

  logic                     in_vld_r;
  logic [1:0]               act_r;
  logic [7:0]               adr_r;
  logic [7:0]               dat_r;
  logic                     out_vld_r;
  logic                     adv;
  logic                     in_take;

  cbsm_pkg::mode_t          mode_r;
  logic                     basic_r;

  cbsm_pkg::bank_t          bank_r;
  logic                     low_en_r;
  logic                     high_en_r;
  logic [ROM_ADDR_BITS-1:0] ofs_lo_r;
  logic [ROM_ADDR_BITS-1:0] ofs_a_r;
  logic [ROM_ADDR_BITS-1:0] ofs_b_r;
  logic                     basic_sel_r;
  logic                     clk_acc_r;

  cbsm_pkg::st_t            cur;
  cbsm_pkg::st_t            st_nxt;
  logic                     clk_acc_nxt;
  logic                     basic_sel_nxt;

  // result register is free or being emptied this cycle
  assign adv      = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      act_r <= in_action;
      adr_r <= in_address_low;
      dat_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      basic_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cbsm_pkg::CFG_MODE:  mode_r  <= cfg_data;
        cbsm_pkg::CFG_BASIC: basic_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cur.bank    = bank_r;
  assign cur.low_en  = low_en_r;
  assign cur.high_en = high_en_r;
  assign cur.ofs_lo  = OW'(ofs_lo_r);
  assign cur.ofs_a   = OW'(ofs_a_r);
  assign cur.ofs_b   = OW'(ofs_b_r);

  cbsm_decode u_decode (
    .cur       (cur),
    .mode      (mode_r),
    .basic     (basic_r),
    .act       (act_r),
    .adr       (adr_r),
    .dat       (dat_r),
    .nxt       (st_nxt),
    .clk_acc   (clk_acc_nxt),
    .basic_sel (basic_sel_nxt)
  );

  // the mapping state doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      bank_r      <= '0;
      low_en_r    <= 1'b0;
      high_en_r   <= 1'b0;
      ofs_lo_r    <= '0;
      ofs_a_r     <= '0;
      ofs_b_r     <= '0;
      basic_sel_r <= 1'b0;
      clk_acc_r   <= 1'b0;
    end else if (adv) begin
      out_vld_r   <= 1'b1;
      bank_r      <= st_nxt.bank;
      low_en_r    <= st_nxt.low_en;
      high_en_r   <= st_nxt.high_en;
      ofs_lo_r    <= st_nxt.ofs_lo[ROM_ADDR_BITS-1:0];
      ofs_a_r     <= st_nxt.ofs_a[ROM_ADDR_BITS-1:0];
      ofs_b_r     <= st_nxt.ofs_b[ROM_ADDR_BITS-1:0];
      basic_sel_r <= basic_sel_nxt;
      clk_acc_r   <= clk_acc_nxt;
    end else if (!out_stall) begin
      out_vld_r   <= 1'b0;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_window_low_on     = low_en_r;
  assign out_window_high_on    = high_en_r;
  assign out_offset_low_window = OW'(ofs_lo_r);
  assign out_offset_a_half     = OW'(ofs_a_r);
  assign out_offset_b_half     = OW'(ofs_b_r);
  assign out_basic_selected    = basic_sel_r;
  assign out_clock_access      = clk_acc_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("advanced word produced no result");

  a_clock_keeps_map: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && clk_acc_nxt) |=> ($stable(bank_r) && $stable(low_en_r) &&
                              $stable(high_en_r) && $stable(ofs_lo_r) &&
                              $stable(ofs_a_r) && $stable(ofs_b_r)))
    else $error("clock page access changed the mapping");

  a_basic_needs_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_basic_selected) |-> out_window_high_on)
    else $error("basic selected with high window off");

endmodule

`default_nettype wire
